// ----- rtl/core/hse_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the heap sort engine
// no dependencies

package hse_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = ADDR_W + 1;
   localparam int IDX_W        = ADDR_W + 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;

   typedef struct packed {
      data_type value;
      logic     last;
   } req_type;

   typedef struct packed {
      data_type sorted_value;
      logic     last_out;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_NEXT,
      ST_GET_NODE,
      ST_GET_ROOT,
      ST_GET_TAIL,
      ST_LEFT_RD,
      ST_LEFT_CMP,
      ST_RIGHT_CMP,
      ST_DECIDE,
      ST_PLACE,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/core/hse_store.sv -----
`timescale 1ns / 1ps
// element store: one write port, one read port with registered read data
// depends on hse_pkg

module hse_store (
   input  logic                clock,
   input  hse_pkg::mem_req_type mem_req,
   output hse_pkg::data_type    rd_data
);
   import hse_pkg::*;

   data_type mem_ff [MAX_ELEMENTS];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      // read data holds when no read is issued
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/hse_seq.sv -----
`timescale 1ns / 1ps
// sequencer for load, heap build, extraction and result streaming
// one shared signed comparator; depends on hse_pkg and the store read data

module hse_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hse_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hse_pkg::rsp_type     rsp_data,
   output hse_pkg::mem_req_type mem_req,
   input  hse_pkg::data_type    rd_data
);
   import hse_pkg::*;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   logic      dropped_ff, dropped_in;
   cnt_type   size_ff, size_in;
   cnt_type   n_ff, n_in;
   cnt_type   idx_ff, idx_in;
   logic      build_ff, build_in;
   addr_type  node_ff, node_in;
   addr_type  top_ff, top_in;
   data_type  node_val_ff, node_val_in;
   data_type  top_val_ff, top_val_in;
   data_type  root_ff, root_in;
   cnt_type   emit_ff, emit_in;
   logic      pend_ff, pend_in;
   logic      pend_last_ff, pend_last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   idx_type   left_idx, right_idx;
   cnt_type   idx_m1, emit_p1, count_new;
   logic      has_left, has_right, gt, room, req_fire, out_free, move, rd_issue;

   // shared compare unit
   assign gt = rd_data > top_val_ff;

   assign left_idx  = {1'b0, node_ff, 1'b1};
   assign right_idx = left_idx + 1'b1;
   assign has_left  = left_idx < IDX_W'(size_ff);
   assign has_right = right_idx < IDX_W'(size_ff);
   assign idx_m1    = idx_ff - 1'b1;
   assign emit_p1   = emit_ff + 1'b1;
   assign room      = count_ff < CNT_W'(MAX_ELEMENTS);
   assign count_new = room ? count_ff + 1'b1 : count_ff;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = pend_ff && out_free;
   assign rd_issue  = (emit_ff != n_ff) && (!pend_ff || move);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_data.last) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (build_ff) begin
               if (idx_ff != '0) state_in = ST_GET_NODE;
            end else if (idx_ff <= CNT_W'(1)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_GET_ROOT;
            end
         end
         ST_GET_NODE:  state_in = ST_LEFT_RD;
         ST_GET_ROOT:  state_in = ST_GET_TAIL;
         ST_GET_TAIL:  state_in = ST_LEFT_RD;
         ST_LEFT_RD:   state_in = has_left ? ST_LEFT_CMP : ST_PLACE;
         ST_LEFT_CMP:  state_in = has_right ? ST_RIGHT_CMP : ST_DECIDE;
         ST_RIGHT_CMP: state_in = ST_DECIDE;
         ST_DECIDE:    state_in = (top_ff == node_ff) ? ST_PLACE : ST_LEFT_RD;
         ST_PLACE:     state_in = ST_NEXT;
         ST_EMIT: begin
            if (emit_ff == n_ff && !pend_ff) state_in = ST_LOAD;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      size_in      = size_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      build_in     = build_ff;
      node_in      = node_ff;
      top_in       = top_ff;
      node_val_in  = node_val_ff;
      top_val_in   = top_val_ff;
      root_in      = root_ff;
      emit_in      = emit_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_req      = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (room) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = count_ff[ADDR_W-1:0];
                  mem_req.wr_data = req_data.value;
               end else begin
                  dropped_in = 1'b1;
               end
               count_in = count_new;
               if (req_data.last) begin
                  size_in  = count_new;
                  n_in     = count_new;
                  idx_in   = count_new >> 1;
                  build_in = 1'b1;
               end
            end
         end
         ST_NEXT: begin
            if (build_ff) begin
               if (idx_ff == '0) begin
                  build_in = 1'b0;
                  idx_in   = n_ff;
               end else begin
                  node_in         = idx_m1[ADDR_W-1:0];
                  idx_in          = idx_m1;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_m1[ADDR_W-1:0];
               end
            end else if (idx_ff <= CNT_W'(1)) begin
               emit_in = '0;
               pend_in = 1'b0;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = '0;
            end
         end
         ST_GET_NODE: begin
            node_val_in = rd_data;
         end
         ST_GET_ROOT: begin
            root_in         = rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_m1[ADDR_W-1:0];
         end
         ST_GET_TAIL: begin
            // old root goes to the end, tail element sifts down from the root
            node_val_in     = rd_data;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_m1[ADDR_W-1:0];
            mem_req.wr_data = root_ff;
            node_in         = '0;
            size_in         = idx_m1;
            idx_in          = idx_m1;
         end
         ST_LEFT_RD: begin
            top_in     = node_ff;
            top_val_in = node_val_ff;
            if (has_left) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = left_idx[ADDR_W-1:0];
            end
         end
         ST_LEFT_CMP: begin
            if (gt) begin
               top_in     = left_idx[ADDR_W-1:0];
               top_val_in = rd_data;
            end
            if (has_right) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = right_idx[ADDR_W-1:0];
            end
         end
         ST_RIGHT_CMP: begin
            if (gt) begin
               top_in     = right_idx[ADDR_W-1:0];
               top_val_in = rd_data;
            end
         end
         ST_DECIDE: begin
            // larger child moves up into the hole
            if (top_ff != node_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = node_ff;
               mem_req.wr_data = top_val_ff;
               node_in         = top_ff;
            end
         end
         ST_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = node_ff;
            mem_req.wr_data = node_val_ff;
         end
         ST_EMIT: begin
            if (move) begin
               rsp_valid_in        = 1'b1;
               rsp_in.sorted_value = rd_data;
               rsp_in.last_out     = pend_last_ff;
               rsp_in.overflow     = dropped_ff;
            end
            if (rd_issue) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = emit_ff[ADDR_W-1:0];
               emit_in         = emit_p1;
               pend_last_in    = (emit_p1 == n_ff);
               pend_in         = 1'b1;
            end else if (move) begin
               pend_in = 1'b0;
            end
            if (emit_ff == n_ff && !pend_ff) begin
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         build_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emit_ff      <= '0;
         idx_ff       <= '0;
         size_ff      <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         build_ff     <= build_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_ff      <= emit_in;
         idx_ff       <= idx_in;
         size_ff      <= size_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      top_ff       <= top_in;
      node_val_ff  <= node_val_in;
      top_val_ff   <= top_val_in;
      root_ff      <= root_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/heap_sort_engine_top.sv -----
`timescale 1ns / 1ps
// heap sort engine top level: sequencer plus element store
// depends on hse_pkg, hse_seq, hse_store
//
// Collects up to MAX_ELEMENTS signed 32-bit words, one per cycle; the word
// flagged last closes the set. Words arriving with the store full are dropped
// and every result of that set then carries overflow. After the last word the
// engine heap sorts in place and streams the set in ascending order, one word
// per cycle when the sink keeps up, flagging the final word with last_out.
// Sorting runs through one shared comparator and a store with one read and one
// write port, so each sift-down level steps through reading the left child,
// comparing it, comparing the right child and moving the larger child up.
// The input is not ready while a set is being sorted or emitted.

module heap_sort_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hse_pkg::rsp_type rsp_data
);
   import hse_pkg::*;

   mem_req_type mem_req;
   data_type    rd_data;

   hse_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   hse_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for heap_sort_engine_top: random and directed sets, checked in order
// depends on hse_pkg and the heap sort engine rtl

module tb_top;
   import hse_pkg::*;

   localparam int       RANDOM_WORDS   = 300;
   localparam int       WATCHDOG_LIMIT = 20000;
   localparam int       END_DRAIN      = 50;
   localparam data_type DATA_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN       = {1'b1, {(DATA_W-1){1'b0}}};

   class sort_scoreboard;
      data_type set_words[$];
      bit       set_dropped;
      rsp_type  sorted_words[$];
      int       errors;

      function new();
         set_dropped = 1'b0;
         errors      = 0;
      endfunction

      function int pending();
         return sorted_words.size();
      endfunction

      // collect the set; on the last word, sort it and queue the expected stream
      function void note_word(req_type w);
         data_type key;
         int       j;
         rsp_type  r;
         if (set_words.size() < MAX_ELEMENTS) begin
            set_words.push_back(w.value);
         end else begin
            set_dropped = 1'b1;
         end
         if (w.last) begin
            // equal values are indistinguishable, so any ascending sort gives the same stream
            for (int i = 1; i < set_words.size(); i++) begin
               key = set_words[i];
               j   = i - 1;
               while (j >= 0 && set_words[j] > key) begin
                  set_words[j+1] = set_words[j];
                  j--;
               end
               set_words[j+1] = key;
            end
            foreach (set_words[i]) begin
               r.sorted_value = set_words[i];
               r.last_out     = (i == set_words.size() - 1);
               r.overflow     = set_dropped;
               sorted_words.push_back(r);
            end
            set_words.delete();
            set_dropped = 1'b0;
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (sorted_words.size() == 0) begin
            $display("%0t: unexpected word: value %0d last_out %0b overflow %0b",
                     $time, got.sorted_value, got.last_out, got.overflow);
            errors++;
            return;
         end
         want = sorted_words.pop_front();
         if (got.sorted_value !== want.sorted_value || got.last_out !== want.last_out ||
             got.overflow !== want.overflow) begin
            $display("%0t: word mismatch: expected value %0d last_out %0b overflow %0b",
                     $time, want.sorted_value, want.last_out, want.overflow);
            $display("%0t:                got value %0d last_out %0b overflow %0b",
                     $time, got.sorted_value, got.last_out, got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sort_scoreboard sort_sb = new();

   int hold_left = 0;
   int sets_seen = 0;
   bit calm      = 1'b0;

   heap_sort_engine_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial forever #5 clock = ~clock;

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic data_type rand_value(data_type prev);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return data_type'($urandom);
         5, 6:          return data_type'($urandom_range(0, 16)) - 8;
         7: begin
            case ($urandom_range(0, 3))
               0:       return DATA_MIN;
               1:       return DATA_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         8:       return prev;
         default: return data_type'($urandom) >>> $urandom_range(1, 30);
      endcase
   endfunction

   task automatic send_word(input data_type word_value, input logic word_last, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value: word_value, last: word_last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_directed();
      // single-word sets at both extremes
      send_word(DATA_MAX, 1'b1, 1'b0);
      send_word(DATA_MIN, 1'b1, 1'b1);
      // extremes mixed with duplicates
      send_word(DATA_MAX, 1'b0, 1'b1);
      send_word(DATA_MIN, 1'b0, 1'b1);
      send_word(32'sd0, 1'b0, 1'b0);
      send_word(-32'sd1, 1'b0, 1'b0);
      send_word(32'sd1, 1'b0, 1'b1);
      send_word(DATA_MAX, 1'b0, 1'b0);
      send_word(DATA_MIN, 1'b0, 1'b1);
      send_word(32'sd5, 1'b0, 1'b1);
      send_word(32'sd5, 1'b0, 1'b0);
      send_word(-32'sd5, 1'b1, 1'b0);
      // reverse-ordered set
      send_word(32'sd3, 1'b0, 1'b1);
      send_word(32'sd2, 1'b0, 1'b1);
      send_word(32'sd1, 1'b0, 1'b1);
      send_word(32'sd0, 1'b1, 1'b1);
      // smallest multi-word set
      send_word(32'sd7, 1'b0, 1'b0);
      send_word(-32'sd7, 1'b1, 1'b0);
   endtask

   task automatic run_random();
      int       sent;
      int       set_idx;
      int       set_size;
      bit       no_gaps;
      data_type v;
      sent    = 0;
      set_idx = 0;
      v       = '0;
      while (sent < RANDOM_WORDS) begin
         // a full store, a set whose last word is dropped, and a longer overflow
         if (set_idx == 1) set_size = MAX_ELEMENTS;
         else if (set_idx == 4) set_size = MAX_ELEMENTS + 1;
         else if (set_idx == 8) set_size = MAX_ELEMENTS + $urandom_range(2, 6);
         else if ($urandom_range(0, 4) == 0) set_size = $urandom_range(9, 24);
         else set_size = $urandom_range(1, 8);
         no_gaps = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < set_size; k++) begin
            v = rand_value(v);
            send_word(v, k == set_size - 1, no_gaps);
         end
         sent += set_size;
         set_idx++;
      end
   endtask

   // sink side: random stalls, calm stretches, and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         sets_seen = 0;
         calm      = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready && rsp_data.last_out) begin
            sets_seen++;
            calm = ($urandom_range(0, 3) == 0);
            // back up the engine while the source keeps offering words
            if (sets_seen == 3) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 15) begin
            hold_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sort_sb.note_word(req_data);
      if (!reset && rsp_valid && rsp_ready) sort_sb.check_word(rsp_data);
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("heap_sort_engine_top verification failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      // let the monitor note the final word before polling the expected stream
      @(posedge clock);
      while (sort_sb.pending() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);
      if (sort_sb.errors == 0) begin
         $display("heap_sort_engine_top verification clean");
      end else begin
         $display("heap_sort_engine_top verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/hse_pkg.sv
rtl/core/hse_store.sv
rtl/core/hse_seq.sv
rtl/core/heap_sort_engine_top.sv
verif/tb_top.sv
